// ===== rtl/llbb_pkg.sv =====
`timescale 1ns / 1ps

package llbb_pkg;

  localparam int unsigned RANGE_W    = 16;
  localparam int unsigned LABEL_W    = 8;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned PIDX_W     = 11;
  localparam int unsigned COORD_W    = 17;
  localparam int unsigned CORNER_W   = 18;
  localparam int unsigned MARGIN_W   = 16;
  localparam int unsigned ATAN_W     = 32;
  localparam int unsigned ATAN_DEPTH = 24;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // CORDIC gain 0.60725293500888 in Q30
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_START_ANGLE = 2'd0;
  localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;
  localparam logic [1:0] REG_BOX_MARGIN  = 2'd2;

  localparam logic [ANGLE_W-1:0]  START_ANGLE_RST = 16'd0;
  localparam logic [ANGLE_W-1:0]  ANGLE_STEP_RST  = 16'd46;
  localparam logic [MARGIN_W-1:0] BOX_MARGIN_RST  = 16'd30;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one converted point travelling from front to back
  typedef struct packed {
    coord_t               x;
    coord_t               y;
    logic [LABEL_W-1:0]   label;
    logic                 scan_end;
  } point_rec_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] start_angle;
    logic [ANGLE_W-1:0] angle_step;
  } front_cfg_t;

  // atan(2^-i), full circle = 2^32
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/llbb_if.sv =====
`timescale 1ns / 1ps

interface llbb_point_if;
  logic                          valid;
  logic                          ready;
  logic [llbb_pkg::RANGE_W-1:0]  range_mm;
  logic [llbb_pkg::LABEL_W-1:0]  intensity_label;
  logic                          last_point;

  modport source (output valid, output range_mm, output intensity_label,
                  output last_point, input ready);
  modport sink   (input valid, input range_mm, input intensity_label,
                  input last_point, output ready);
endinterface

interface llbb_corner_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [llbb_pkg::CORNER_W-1:0] corner_x;
  logic signed [llbb_pkg::CORNER_W-1:0] corner_y;
  logic                                 box_kind;
  logic [llbb_pkg::LABEL_W-1:0]         box_label;
  logic                                 last_of_run;

  modport source (output valid, output corner_x, output corner_y, output box_kind,
                  output box_label, output last_of_run, input ready);
  modport sink   (input valid, input corner_x, input corner_y, input box_kind,
                  input box_label, input last_of_run, output ready);
endinterface

// ===== rtl/llbb_front.sv =====
`timescale 1ns / 1ps

module llbb_front #(
  parameter int unsigned POINTS_PER_SCAN = 1440,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  llbb_pkg::front_cfg_t   cfg,
  llbb_point_if.sink             points,
  output logic                   rec_valid,
  input  logic                   rec_ready,
  output llbb_pkg::point_rec_t   rec
);

  localparam int unsigned NSTEPS = (CORDIC_STEPS < llbb_pkg::ATAN_DEPTH) ?
                                   CORDIC_STEPS : llbb_pkg::ATAN_DEPTH;
  localparam int unsigned STEP_W = $clog2(NSTEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);
  localparam logic [llbb_pkg::PIDX_W-1:0] LAST_INDEX =
    llbb_pkg::PIDX_W'(POINTS_PER_SCAN - 1);

  localparam int unsigned PROD_W = llbb_pkg::RANGE_W + 30;
  localparam int unsigned XW     = 35;
  localparam int unsigned ZW     = 33;
  localparam int unsigned CW     = XW - 16;
  localparam int unsigned SPROD_W = llbb_pkg::ANGLE_W + llbb_pkg::PIDX_W;

  localparam logic signed [CW-1:0] CLAMP_HI = CW'(65535);
  localparam logic signed [CW-1:0] CLAMP_LO = -CLAMP_HI;
  localparam logic signed [XW-1:0] ROUND_HALF = XW'(32768);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_ITER = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                      state;
  logic [llbb_pkg::PIDX_W-1:0]     pidx;
  logic [STEP_W-1:0]               cnt;
  logic [llbb_pkg::RANGE_W-1:0]    range_r;
  logic [llbb_pkg::LABEL_W-1:0]    label_r;
  logic                            end_r;
  logic [llbb_pkg::ANGLE_W-1:0]    angle;
  logic [1:0]                      quad;
  logic signed [ZW-1:0]            z;
  logic signed [XW-1:0]            xr;
  logic signed [XW-1:0]            yr;

  logic                            accept;
  logic                            scan_end;
  logic [SPROD_W-1:0]              step_prod;
  logic [llbb_pkg::ANGLE_W-1:0]    ang_rnd;
  logic [1:0]                      quad_w;
  logic [llbb_pkg::ANGLE_W-1:0]    resid;
  logic [PROD_W-1:0]               gain_prod;
  logic [PROD_W-1:0]               x_init;
  logic signed [XW-1:0]            dx;
  logic signed [XW-1:0]            dy;
  logic signed [ZW-1:0]            at;
  logic signed [XW-1:0]            xr_rnd;
  logic signed [XW-1:0]            yr_rnd;
  logic signed [CW-1:0]            cos_v;
  logic signed [CW-1:0]            sin_v;
  logic signed [CW-1:0]            rot_x;
  logic signed [CW-1:0]            rot_y;

  function automatic llbb_pkg::coord_t clamp17(input logic signed [CW-1:0] v);
    llbb_pkg::coord_t r;
    if (v > CLAMP_HI) begin
      r = CLAMP_HI[llbb_pkg::COORD_W-1:0];
    end else if (v < CLAMP_LO) begin
      r = CLAMP_LO[llbb_pkg::COORD_W-1:0];
    end else begin
      r = v[llbb_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  assign points.ready = (state == ST_IDLE);
  assign accept       = points.valid && points.ready;
  assign scan_end     = points.last_point || (pidx >= LAST_INDEX);
  assign step_prod    = cfg.angle_step * pidx;

  // quadrant split and residual angle
  assign ang_rnd = angle + 16'd8192;
  assign quad_w  = ang_rnd[15:14];
  assign resid   = angle - {quad_w, 14'd0};

  // start vector, range scaled by the CORDIC gain
  assign gain_prod = range_r * llbb_pkg::GAIN_Q30;
  assign x_init    = gain_prod + PROD_W'(8192);

  // one micro-rotation
  assign dx = yr >>> cnt;
  assign dy = xr >>> cnt;
  assign at = signed'({1'b0, llbb_pkg::atan_entry(5'(cnt))});

  // round to millimetres and undo the quadrant split
  assign xr_rnd = xr + ROUND_HALF;
  assign yr_rnd = yr + ROUND_HALF;
  assign cos_v  = xr_rnd[XW-1:16];
  assign sin_v  = yr_rnd[XW-1:16];

  always_comb begin
    case (quad)
      2'd0: begin
        rot_x = cos_v;
        rot_y = sin_v;
      end
      2'd1: begin
        rot_x = -sin_v;
        rot_y = cos_v;
      end
      2'd2: begin
        rot_x = -cos_v;
        rot_y = -sin_v;
      end
      default: begin
        rot_x = sin_v;
        rot_y = -cos_v;
      end
    endcase
  end

  assign rec_valid    = (state == ST_DONE);
  assign rec.x        = clamp17(rot_x);
  assign rec.y        = clamp17(rot_y);
  assign rec.label    = label_r;
  assign rec.scan_end = end_r;

  // sequence control and scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pidx  <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOAD;
            pidx  <= scan_end ? '0 : pidx + 1'b1;
          end
        end
        ST_LOAD: begin
          state <= ST_ITER;
          cnt   <= '0;
        end
        ST_ITER: begin
          if (cnt == LAST_STEP) begin
            state <= ST_DONE;
          end
          cnt <= cnt + 1'b1;
        end
        default: begin
          if (rec_ready) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          range_r <= points.range_mm;
          label_r <= points.intensity_label;
          end_r   <= scan_end;
          angle   <= cfg.start_angle + step_prod[llbb_pkg::ANGLE_W-1:0];
        end
      end
      ST_LOAD: begin
        quad <= quad_w;
        z    <= {resid[15], resid, 16'd0};
        xr   <= XW'(x_init[PROD_W-1:14]);
        yr   <= '0;
      end
      ST_ITER: begin
        if (!z[ZW-1]) begin
          xr <= xr - dx;
          yr <= yr + dy;
          z  <= z - at;
        end else begin
          xr <= xr + dx;
          yr <= yr - dy;
          z  <= z + at;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) pidx <= LAST_INDEX)
    else $error("point index ran past the end of the scan");

  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_ITER && cnt == LAST_STEP) |=> rec_valid)
    else $error("rotation finished without a record");

endmodule

// ===== rtl/llbb_queue.sv =====
`timescale 1ns / 1ps

module llbb_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  llbb_pkg::point_rec_t  in_rec,
  output logic                  out_valid,
  input  logic                  out_ready,
  output llbb_pkg::point_rec_t  out_rec
);

  llbb_pkg::point_rec_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_rec   = mem[rd_ptr];

  // hold records between front and back
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_rec;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue occupancy out of range");

endmodule

// ===== rtl/llbb_back.sv =====
`timescale 1ns / 1ps

module llbb_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [llbb_pkg::MARGIN_W-1:0]  box_margin,
  input  logic                           rec_valid,
  output logic                           rec_ready,
  input  llbb_pkg::point_rec_t           rec,
  llbb_corner_if.source                  corners
);

  typedef struct packed {
    llbb_pkg::coord_t lo_x;
    llbb_pkg::coord_t hi_x;
    llbb_pkg::coord_t lo_y;
    llbb_pkg::coord_t hi_y;
  } box_t;

  localparam int unsigned CW = llbb_pkg::CORNER_W;

  // box state
  logic [llbb_pkg::LABEL_W-1:0] cur_label;
  logic                         group_open;
  logic                         one_open;
  box_t                         gbox;
  box_t                         obox;

  // boxes waiting to be drawn: closed group, final group, label-one
  logic [2:0]                   pending;
  box_t                         slot_box [3];
  logic [llbb_pkg::LABEL_W-1:0] slot_label [2];
  logic [2:0]                   corner;

  // output register
  logic                         out_valid;
  logic signed [CW-1:0]         out_x;
  logic signed [CW-1:0]         out_y;
  logic                         out_kind;
  logic [llbb_pkg::LABEL_W-1:0] out_label;
  logic                         out_last;

  logic                         pop;
  logic                         has_ret;
  logic                         grow_g;
  logic                         start_g;
  logic                         close_g;
  logic                         is_one;
  box_t                         pt_box;
  box_t                         g_new;
  box_t                         o_new;
  logic [llbb_pkg::LABEL_W-1:0] label_new;
  logic                         gopen_new;
  logic                         oopen_new;

  logic [1:0]                   sel;
  logic [2:0]                   sel_mask;
  logic [2:0]                   rest;
  box_t                         cur_box;
  logic signed [CW-1:0]         lx;
  logic signed [CW-1:0]         hx;
  logic signed [CW-1:0]         ly;
  logic signed [CW-1:0]         hy;
  logic signed [CW-1:0]         m_ext;
  logic                         use_hx;
  logic                         use_hy;
  logic                         advance;

  function automatic box_t grow(input box_t b, input llbb_pkg::coord_t x,
                                input llbb_pkg::coord_t y);
    box_t r;
    r = b;
    if (x < b.lo_x) r.lo_x = x;
    if (x > b.hi_x) r.hi_x = x;
    if (y < b.lo_y) r.lo_y = y;
    if (y > b.hi_y) r.hi_y = y;
    return r;
  endfunction

  // classify the record against the open boxes
  assign rec_ready = (pending == 3'b000);
  assign pop       = rec_valid && rec_ready;
  assign has_ret   = (rec.label != '0);
  assign grow_g    = has_ret && group_open && (rec.label == cur_label);
  assign start_g   = has_ret && !grow_g && (rec.label > cur_label);
  assign close_g   = start_g && group_open;
  assign is_one    = has_ret && (rec.label == llbb_pkg::LABEL_W'(1));
  assign pt_box    = '{lo_x: rec.x, hi_x: rec.x, lo_y: rec.y, hi_y: rec.y};

  always_comb begin
    if (grow_g) begin
      g_new = grow(gbox, rec.x, rec.y);
    end else if (start_g) begin
      g_new = pt_box;
    end else begin
      g_new = gbox;
    end
    if (is_one) begin
      o_new = one_open ? grow(obox, rec.x, rec.y) : pt_box;
    end else begin
      o_new = obox;
    end
  end

  assign label_new = start_g ? rec.label : cur_label;
  assign gopen_new = group_open || start_g;
  assign oopen_new = one_open || is_one;

  // pick the lowest pending box and form its corner
  always_comb begin
    if (pending[0]) begin
      sel = 2'd0;
    end else if (pending[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  assign sel_mask = 3'b001 << sel;
  assign rest     = pending & ~sel_mask;
  assign cur_box  = slot_box[sel];
  assign m_ext    = signed'({2'b00, box_margin});
  assign lx       = {cur_box.lo_x[llbb_pkg::COORD_W-1], cur_box.lo_x} - m_ext;
  assign hx       = {cur_box.hi_x[llbb_pkg::COORD_W-1], cur_box.hi_x} + m_ext;
  assign ly       = {cur_box.lo_y[llbb_pkg::COORD_W-1], cur_box.lo_y} - m_ext;
  assign hy       = {cur_box.hi_y[llbb_pkg::COORD_W-1], cur_box.hi_y} + m_ext;
  assign use_hx   = corner inside {[3'd3:3'd6]};
  assign use_hy   = corner inside {[3'd1:3'd4]};
  assign advance  = (pending != 3'b000) && (!out_valid || corners.ready);

  // box state and draw sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_label  <= llbb_pkg::LABEL_W'(1);
      group_open <= 1'b0;
      one_open   <= 1'b0;
      pending    <= 3'b000;
      corner     <= 3'd0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        pending <= {rec.scan_end && oopen_new, rec.scan_end && gopen_new, close_g};
        if (rec.scan_end) begin
          cur_label  <= llbb_pkg::LABEL_W'(1);
          group_open <= 1'b0;
          one_open   <= 1'b0;
        end else begin
          cur_label  <= label_new;
          group_open <= gopen_new;
          one_open   <= oopen_new;
        end
      end else if (advance) begin
        corner <= corner + 1'b1;
        if (corner == 3'd7) begin
          pending <= rest;
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (corners.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // bounds, snapshots and output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      gbox          <= g_new;
      obox          <= o_new;
      slot_box[0]   <= gbox;
      slot_box[1]   <= g_new;
      slot_box[2]   <= o_new;
      slot_label[0] <= cur_label;
      slot_label[1] <= label_new;
    end
    if (advance) begin
      out_x     <= use_hx ? hx : lx;
      out_y     <= use_hy ? hy : ly;
      out_kind  <= (sel == 2'd2);
      out_label <= (sel == 2'd2) ? llbb_pkg::LABEL_W'(1) : slot_label[sel[0]];
      out_last  <= (corner == 3'd7) && (rest == 3'b000);
    end
  end

  assign corners.valid       = out_valid;
  assign corners.corner_x    = out_x;
  assign corners.corner_y    = out_y;
  assign corners.box_kind    = out_kind;
  assign corners.box_label   = out_label;
  assign corners.last_of_run = out_last;

  assert property (@(posedge clk) disable iff (rst) cur_label != '0)
    else $error("group label dropped to zero");

  assert property (@(posedge clk) disable iff (rst)
                   (corner != 3'd0) |-> (pending != 3'b000))
    else $error("corner count running with no box to draw");

  assert property (@(posedge clk) disable iff (rst)
                   (pending[0] && !pending[1]) |-> group_open || !$past(rec.scan_end))
    else $error("closed group box left without a following group");

endmodule

// ===== rtl/lidar_label_bounding_boxes.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Protocol           Payload
// points    in   valid/ready        range_mm, intensity_label, last_point
// corners   out  valid/ready        corner_x, corner_y, box_kind, box_label, last_of_run
// apb       in   psel/penable/...   start_angle @0x0, angle_step @0x4, box_margin @0x8
//
// A point request passes through the front's load, iteration and done states,
// the CORDIC unit doing one micro-rotation per cycle.
// The back draws one endpoint per cycle unless corners stalls, up to 24 per point;
// a two-entry record queue lets the front convert the next point while endpoints drain.
// Reset is synchronous: registers return to their reset values and both boxes close.
// A stall on corners holds the output register; the queue then fills and points
// stalls once the front finishes its current point.
module lidar_label_bounding_boxes #(
  parameter int unsigned POINTS_PER_SCAN = 1440,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [llbb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [llbb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [llbb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  llbb_point_if.sink                       points,
  llbb_corner_if.source                    corners
);

  logic [llbb_pkg::ANGLE_W-1:0]  start_angle;
  logic [llbb_pkg::ANGLE_W-1:0]  angle_step;
  logic [llbb_pkg::MARGIN_W-1:0] box_margin;
  logic [1:0]                    reg_idx;
  logic                          wr_en;

  llbb_pkg::front_cfg_t          front_cfg;
  logic                          f_valid;
  logic                          f_ready;
  llbb_pkg::point_rec_t          f_rec;
  logic                          b_valid;
  logic                          b_ready;
  llbb_pkg::point_rec_t          b_rec;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle <= llbb_pkg::START_ANGLE_RST;
      angle_step  <= llbb_pkg::ANGLE_STEP_RST;
      box_margin  <= llbb_pkg::BOX_MARGIN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        llbb_pkg::REG_START_ANGLE: start_angle <= pwdata[llbb_pkg::ANGLE_W-1:0];
        llbb_pkg::REG_ANGLE_STEP:  angle_step  <= pwdata[llbb_pkg::ANGLE_W-1:0];
        llbb_pkg::REG_BOX_MARGIN:  box_margin  <= pwdata[llbb_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      llbb_pkg::REG_START_ANGLE: prdata = llbb_pkg::APB_DATA_W'(start_angle);
      llbb_pkg::REG_ANGLE_STEP:  prdata = llbb_pkg::APB_DATA_W'(angle_step);
      llbb_pkg::REG_BOX_MARGIN:  prdata = llbb_pkg::APB_DATA_W'(box_margin);
      default:                   prdata = '0;
    endcase
  end

  assign front_cfg.start_angle = start_angle;
  assign front_cfg.angle_step  = angle_step;

  llbb_front #(
    .POINTS_PER_SCAN (POINTS_PER_SCAN),
    .CORDIC_STEPS    (CORDIC_STEPS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (front_cfg),
    .points    (points),
    .rec_valid (f_valid),
    .rec_ready (f_ready),
    .rec       (f_rec)
  );

  llbb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_rec    (f_rec),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_rec   (b_rec)
  );

  llbb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .box_margin (box_margin),
    .rec_valid  (b_valid),
    .rec_ready  (b_ready),
    .rec        (b_rec),
    .corners    (corners)
  );

endmodule

// ===== verif/llbb_corner_checker.sv =====
`timescale 1ns / 1ps

module llbb_corner_checker #(
  parameter int unsigned POINTS_PER_SCAN = 1440,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [llbb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [llbb_pkg::APB_DATA_W-1:0] pwdata,
  llbb_point_if                           points,
  llbb_corner_if                          corners,
  output int                              mismatches,
  output int                              pending,
  output int                              corners_checked
);

  localparam int unsigned ROTATIONS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam longint      GAIN      = 64'd652032874;
  localparam int          COORD_LIM = 65535;
  localparam real         PI        = 3.14159265358979323846;
  localparam logic        KIND_GROUP = 1'b0;
  localparam logic        KIND_ONES  = 1'b1;

  typedef struct packed {
    int lo_x;
    int hi_x;
    int lo_y;
    int hi_y;
  } box_t;

  typedef struct packed {
    logic signed [llbb_pkg::CORNER_W-1:0] x;
    logic signed [llbb_pkg::CORNER_W-1:0] y;
    logic                                 kind;
    logic [llbb_pkg::LABEL_W-1:0]         label;
    logic                                 last;
  } corner_t;

  corner_t                      corners_due [$];
  longint                       atan_turn [24];
  int unsigned                  start_angle, angle_step;
  int                           margin_mm;
  int unsigned                  scan_index;
  logic [llbb_pkg::LABEL_W-1:0] open_label;
  logic                         group_live, ones_live;
  box_t                         group_box, ones_box;
  int                           run_len;
  int                           fails;
  int                           checked;

  // atan(2^-i) in units of 2^-32 turn, rounded
  initial begin : atan_init
    int k;
    for (k = 0; k < 24; k++)
      atan_turn[k] = longint'($rtoi($atan(2.0 ** (-k)) * 4294967296.0 / (2.0 * PI) + 0.5));
  end

  function automatic int clamp_coord(input longint v);
    if (v > COORD_LIM) return COORD_LIM;
    if (v < -COORD_LIM) return -COORD_LIM;
    return int'(v);
  endfunction

  // rotate (range, 0) to the requested angle, one micro-rotation per step
  function automatic void polar_to_xy(input logic [15:0] rng, input logic [15:0] ang,
                                      output int px, output int py);
    logic [1:0]  quad;
    logic [15:0] resid;
    longint      x, y, z, nx, ny, c, s;
    int          i;
    quad  = 2'((32'(ang) + 32'd8192) >> 14);
    resid = ang - {quad, 14'd0};
    z = longint'($signed(resid)) * 65536;
    x = (longint'(rng) * GAIN + 8192) >>> 14;
    y = 0;
    for (i = 0; i < ROTATIONS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - atan_turn[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + atan_turn[i];
      end
      x = nx;
      y = ny;
    end
    c = (x + 32768) >>> 16;
    s = (y + 32768) >>> 16;
    // turn back by whole quadrants
    case (quad)
      2'd0: begin
        nx = c;
        ny = s;
      end
      2'd1: begin
        nx = -s;
        ny = c;
      end
      2'd2: begin
        nx = -c;
        ny = -s;
      end
      default: begin
        nx = s;
        ny = -c;
      end
    endcase
    px = clamp_coord(nx);
    py = clamp_coord(ny);
  endfunction

  function automatic box_t point_box(input int x, input int y);
    box_t b;
    b.lo_x = x;
    b.hi_x = x;
    b.lo_y = y;
    b.hi_y = y;
    return b;
  endfunction

  function automatic box_t grown(input box_t b, input int x, input int y);
    box_t g;
    g = b;
    if (x < g.lo_x) g.lo_x = x;
    if (x > g.hi_x) g.hi_x = x;
    if (y < g.lo_y) g.lo_y = y;
    if (y > g.hi_y) g.hi_y = y;
    return g;
  endfunction

  function automatic void push_corner(input int x, input int y, input logic kind,
                                      input logic [llbb_pkg::LABEL_W-1:0] label);
    corner_t c;
    c.x     = x[llbb_pkg::CORNER_W-1:0];
    c.y     = y[llbb_pkg::CORNER_W-1:0];
    c.kind  = kind;
    c.label = label;
    c.last  = 1'b0;
    corners_due.insert(corners_due.size(), c);
    run_len++;
  endfunction

  // four lines of the widened box, two endpoints each
  function automatic void queue_box(input box_t b, input logic kind,
                                    input logic [llbb_pkg::LABEL_W-1:0] label);
    int lx, hx, ly, hy;
    lx = b.lo_x - margin_mm;
    hx = b.hi_x + margin_mm;
    ly = b.lo_y - margin_mm;
    hy = b.hi_y + margin_mm;
    push_corner(lx, ly, kind, label);
    push_corner(lx, hy, kind, label);
    push_corner(lx, hy, kind, label);
    push_corner(hx, hy, kind, label);
    push_corner(hx, hy, kind, label);
    push_corner(hx, ly, kind, label);
    push_corner(hx, ly, kind, label);
    push_corner(lx, ly, kind, label);
  endfunction

  function automatic void clear_scan();
    scan_index = 0;
    open_label = 8'd1;
    group_live = 1'b0;
    ones_live  = 1'b0;
  endfunction

  // fold one point into the boxes and queue the endpoints it releases
  function automatic void fold_point(input logic [15:0] rng,
                                     input logic [llbb_pkg::LABEL_W-1:0] lbl,
                                     input logic lastp);
    int      px, py;
    logic    scan_done;
    run_len = 0;
    if (lbl != 0) begin
      polar_to_xy(rng, 16'(start_angle + angle_step * scan_index), px, py);
      if (group_live && lbl == open_label) begin
        group_box = grown(group_box, px, py);
      end else if (lbl > open_label) begin
        if (group_live) queue_box(group_box, KIND_GROUP, open_label);
        open_label = lbl;
        group_live = 1'b1;
        group_box  = point_box(px, py);
      end
      if (lbl == 8'd1) begin
        ones_box  = ones_live ? grown(ones_box, px, py) : point_box(px, py);
        ones_live = 1'b1;
      end
    end
    scan_done = lastp || (scan_index >= POINTS_PER_SCAN - 1);
    if (scan_done) begin
      if (group_live) queue_box(group_box, KIND_GROUP, open_label);
      if (ones_live) queue_box(ones_box, KIND_ONES, 8'd1);
      clear_scan();
    end else begin
      scan_index = (scan_index + 1) % 2048;
    end
    // flag the final endpoint of this request
    if (run_len > 0)
      corners_due[corners_due.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    corner_t want;
    if (rst) begin
      start_angle = llbb_pkg::START_ANGLE_RST;
      angle_step  = llbb_pkg::ANGLE_STEP_RST;
      margin_mm   = llbb_pkg::BOX_MARGIN_RST;
      clear_scan();
      corners_due.delete();
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (2'(paddr >> 2))
          llbb_pkg::REG_START_ANGLE: start_angle = pwdata[15:0];
          llbb_pkg::REG_ANGLE_STEP:  angle_step  = pwdata[15:0];
          llbb_pkg::REG_BOX_MARGIN:  margin_mm   = int'(pwdata[15:0]);
          default: ;
        endcase
      end
      // compare each endpoint with the oldest one due
      if (corners.valid && corners.ready) begin
        if (corners_due.size() == 0) begin
          $error("endpoint (%0d, %0d) label %0d arrived with none due",
                 corners.corner_x, corners.corner_y, corners.box_label);
          fails++;
        end else begin
          want = corners_due.pop_front();
          check_field("corner_x", want.x, corners.corner_x);
          check_field("corner_y", want.y, corners.corner_y);
          check_field("box_kind", want.kind, corners.box_kind);
          check_field("box_label", want.label, corners.box_label);
          check_field("last_of_run", want.last, corners.last_of_run);
          checked++;
        end
      end
      if (points.valid && points.ready)
        fold_point(points.range_mm, points.intensity_label, points.last_point);
    end
    mismatches      <= fails;
    pending         <= corners_due.size();
    corners_checked <= checked;
  end

endmodule

// ===== verif/tb_lidar_label_bounding_boxes.sv =====
`timescale 1ns / 1ps

module tb_lidar_label_bounding_boxes;

  localparam int unsigned POINTS_PER_SCAN = 1440;
  localparam int unsigned CORDIC_STEPS    = 16;
  localparam int          SETTLE_CYCLES   = 2 * (CORDIC_STEPS + 3) + 8;
  localparam int          HOLD_CYCLES     = 600;
  localparam int          STALL_LIMIT     = 4000;

  logic                            clk;
  logic                            rst;
  logic                            psel, penable, pwrite, pready;
  logic [llbb_pkg::APB_ADDR_W-1:0] paddr;
  logic [llbb_pkg::APB_DATA_W-1:0] pwdata, prdata;

  int   mismatches, pending, corners_checked;
  int   points_sent, scans_sent;
  int   src_idle_pct, sink_idle_pct;
  logic hold_off_req;

  llbb_point_if  points_ch ();
  llbb_corner_if corners_ch ();

  lidar_label_bounding_boxes #(
    .POINTS_PER_SCAN(POINTS_PER_SCAN),
    .CORDIC_STEPS   (CORDIC_STEPS)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .points (points_ch),
    .corners(corners_ch)
  );

  llbb_corner_checker #(
    .POINTS_PER_SCAN(POINTS_PER_SCAN),
    .CORDIC_STEPS   (CORDIC_STEPS)
  ) box_check (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .points         (points_ch),
    .corners        (corners_ch),
    .mismatches     (mismatches),
    .pending        (pending),
    .corners_checked(corners_checked)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // drive corner ready: random idling, or a long hold-off on request
  initial begin : corner_sink
    int hold_left;
    hold_left = 0;
    corners_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        corners_ch.ready <= 1'b0;
      end else begin
        corners_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // abort when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((points_ch.valid && points_ch.ready) || (corners_ch.valid && corners_ch.ready) ||
          (psel && penable && pwrite && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= llbb_pkg::APB_ADDR_W'({idx, 2'b00});
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] start, input logic [15:0] step,
                           input logic [15:0] margin);
    write_reg(llbb_pkg::REG_START_ANGLE, start);
    write_reg(llbb_pkg::REG_ANGLE_STEP, step);
    write_reg(llbb_pkg::REG_BOX_MARGIN, margin);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // offer one point, idling first at the sender's rate
  task automatic send_point(input logic [15:0] rng, input logic [7:0] lbl, input logic lastp);
    while ($urandom_range(99) < src_idle_pct) begin
      points_ch.valid <= 1'b0;
      @(posedge clk);
    end
    points_ch.valid           <= 1'b1;
    points_ch.range_mm        <= rng;
    points_ch.intensity_label <= lbl;
    points_ch.last_point      <= lastp;
    @(posedge clk);
    while (!points_ch.ready) @(posedge clk);
    points_sent++;
    if (lastp) scans_sent++;
  endtask

  // stop offering and wait for every endpoint due
  task automatic drain();
    points_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // drain, then give points with no endpoints time to leave the front
  task automatic quiesce();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_range();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return 16'd0;
    if (pick == 1) return 16'hFFFF;
    if (pick < 12) return 16'($urandom_range(200, 12000));
    return 16'($urandom);
  endfunction

  // one scan of mostly rising label groups with ones and gaps mixed in
  task automatic send_scan(input int len);
    logic [7:0] top_label, lbl;
    int         pick, n;
    top_label = 8'($urandom_range(1, 4));
    for (n = 0; n < len; n++) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        lbl = 8'd0;
      end else if (pick < 30) begin
        lbl = 8'd1;
      end else if (pick < 42) begin
        lbl = 8'($urandom_range(1, top_label));
      end else if (pick < 68) begin
        lbl = top_label;
      end else begin
        top_label = (top_label > 8'd235) ? 8'd255 : top_label + 8'($urandom_range(1, 20));
        lbl = top_label;
      end
      send_point(pick_range(), lbl, n == len - 1);
    end
  endtask

  task automatic send_noise(input int count);
    int n;
    for (n = 0; n < count; n++)
      send_point(16'($urandom), 8'($urandom), $urandom_range(19) == 0);
  endtask

  task automatic random_points(input int target);
    int first;
    first = points_sent;
    while (points_sent - first < target) begin
      if ($urandom_range(9) < 8)
        send_scan($urandom_range(2, 24));
      else
        send_noise($urandom_range(1, 6));
    end
  endtask

  initial begin : stimulus
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    hold_off_req = 1'b0;
    src_idle_pct = 37;
    sink_idle_pct = 77;
    points_sent  = 0;
    scans_sent   = 0;
    points_ch.valid           = 1'b0;
    points_ch.range_mm        = '0;
    points_ch.intensity_label = '0;
    points_ch.last_point      = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // sixteenth-turn steps so the first scan covers three quadrants
    configure(16'd0, 16'd4096, 16'd30);
    send_point(16'd1000, 8'd0, 1'b0);     // no return
    send_point(16'hFFFF, 8'd1, 1'b0);     // ones before any group
    send_point(16'd0, 8'd2, 1'b0);        // open group
    send_point(16'd1234, 8'd2, 1'b0);     // extend group
    send_point(16'hFFFF, 8'd1, 1'b0);     // lower label, ones only
    send_point(16'd500, 8'd5, 1'b0);      // rising label closes group
    send_point(16'hFFFF, 8'd3, 1'b0);     // lower label ignored
    send_point(16'd700, 8'd255, 1'b0);    // top label closes group
    send_point(16'hFFFF, 8'd255, 1'b0);
    send_point(16'd300, 8'd0, 1'b1);      // end: group and ones box
    send_point(16'd0, 8'd0, 1'b1);        // empty scan
    send_point(16'd4000, 8'd1, 1'b1);     // ones box alone
    send_point(16'hFFFF, 8'd200, 1'b1);   // group box alone
    send_point(16'd100, 8'd1, 1'b0);
    send_point(16'd200, 8'd3, 1'b0);
    send_point(16'd300, 8'd7, 1'b1);      // closing, final and ones box
    quiesce();

    // sender idles lightly, receiver heavily
    configure(16'($urandom), 16'($urandom_range(1, 2000)), 16'd0);
    random_points(145);
    quiesce();

    // the other way round, registers at their top values
    src_idle_pct  = 77;
    sink_idle_pct = 37;
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_points(70);
    drain();
    random_points(75);
    quiesce();

    // no idling; hold the receiver off while points keep coming
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    configure(16'($urandom), 16'd46, 16'($urandom));
    random_points(30);
    hold_off_req = 1'b1;
    random_points(115);
    quiesce();

    configure(16'd0, 16'd0, 16'd1);
    send_scan(8);
    quiesce();

    $display("Run: %0d points in %0d flagged scans, %0d box endpoints compared.",
             points_sent, scans_sent, corners_checked);
    $display("Covered register extremes, idling on both channels and a long output stall "
             , "with the point input backed up.");
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
